// File: rtl/core/averaged_spectrum_peak_finder_assert.svh
// Assertion macros for the averaged spectrum peak finder checker.
// Depends on nothing; included by the checker file.
`ifndef AVERAGED_SPECTRUM_PEAK_FINDER_ASSERT_SVH
`define AVERAGED_SPECTRUM_PEAK_FINDER_ASSERT_SVH

// Concurrent assertion on a named clock, disabled while reset is high.
`define ASPF_ASSERT_CLK(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Same on the block's own clk and rst.
`define ASPF_ASSERT(lbl, prop, msg) \
  `ASPF_ASSERT_CLK(lbl, clk, rst, prop, msg)

`endif

// File: rtl/core/aspf_pkg.sv
// Package for the averaged spectrum peak finder: field widths, register
// indexes, reset values and the control state type. No dependencies.
`timescale 1ns / 1ps

package aspf_pkg;

  localparam int VAL_W      = 15;
  localparam int NB_W       = 10;
  localparam int SB_W       = 9;
  localparam int PBIN_W     = 9;
  localparam int REF_W      = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [VAL_W-1:0] MIN_THRESHOLD = 15'd5;
  localparam logic [NB_W-1:0]  NUM_BINS_RST  = 10'd256;
  localparam logic [SB_W-1:0]  START_BIN_RST = 9'd30;
  localparam logic [VAL_W-1:0] THRESHOLD_RST = 15'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_BINS  = 2'd0,
    REG_START_BIN = 2'd1,
    REG_THRESHOLD = 2'd2
  } aspf_cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_RUN,
    ST_DRAIN,
    ST_FIRST,
    ST_SEARCH,
    ST_CLIMB,
    ST_WINDOW,
    ST_WTAIL,
    ST_DIVGO,
    ST_DIV,
    ST_FINISH
  } aspf_state_t;

endpackage

// File: rtl/core/aspf_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the peak finder top level for the centroid.
`timescale 1ns / 1ps

module aspf_div #(
  parameter int NW = 35,
  parameter int DW = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    dsr;
  logic [DW:0]      rem_sh;
  logic             ge;

  assign rem_sh = {rem, quo[NW-1]};
  assign ge     = (rem_sh >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1));
      if (start) begin
        cnt <= CNT_W'(NW);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dsr <= den;
    end else if (cnt != '0) begin
      quo <= {quo[NW-2:0], ge};
      rem <= ge ? DW'(rem_sh - {1'b0, dsr}) : rem_sh[DW-1:0];
    end
  end

endmodule

// File: rtl/core/averaged_spectrum_peak_finder.sv
// Averaged spectrum peak finder: top level with the spectrum memory,
// frame averaging, peak search, centroid window and result register.
// Depends on aspf_pkg and aspf_div.
`timescale 1ns / 1ps

//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_ready, bin_value                | to block
//  out     | out_valid, out_ready, found, peak_value,     | from block
//          | peak_bin, refined_bin                        |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data    | to block
//
// Within a frame one bin item is taken every cycle (read, average, write back
// through the one-port-read/one-port-write spectrum memory, with forwarding).
// After the last bin the block stops taking items for the scan: drain, first
// read, search and climb over the bins, window pass and tail, divider start
// and division (only for a found peak; no division for a zero window sum), then
// output load. After reset a clearing pass zeroes the memory; no bin is taken
// during it. Config writes are taken at any time (cfg_ready tied high).
// A stalled result holds the scan in its final step; no bins are taken meanwhile.

module averaged_spectrum_peak_finder
  import aspf_pkg::*;
#(
  parameter int MAX_BINS    = 512,
  parameter int WINDOW_HALF = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VAL_W-1:0]      bin_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  found,
  output logic [VAL_W-1:0]      peak_value,
  output logic [PBIN_W-1:0]     peak_bin,
  output logic [REF_W-1:0]      refined_bin,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // memory address, general index (covers start_bin and the frame length)
  localparam int AW    = $clog2(MAX_BINS);
  localparam int CW    = ((AW > SB_W) ? AW : SB_W) + 1;
  localparam int WIN   = 2 * WINDOW_HALF + 1;
  localparam int VSW   = VAL_W + $clog2(WIN + 1);
  localparam int WSW   = VSW + CW;
  localparam int SCALE = 2 * WINDOW_HALF;
  localparam int NW    = WSW + $clog2(SCALE + 1);
  localparam logic [CW-1:0] WHC = CW'(WINDOW_HALF);

  // configuration registers
  logic [NB_W-1:0]  num_bins;
  logic [SB_W-1:0]  start_bin;
  logic [VAL_W-1:0] threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_bins  <= NUM_BINS_RST;
      start_bin <= START_BIN_RST;
      threshold <= THRESHOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NUM_BINS:  num_bins  <= cfg_data[NB_W-1:0];
        REG_START_BIN: start_bin <= cfg_data[SB_W-1:0];
        REG_THRESHOLD: threshold <= cfg_data[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  aspf_state_t state, state_next;

  // effective frame length and threshold
  logic [CW-1:0]    len, nb_x, start_x;
  logic [VAL_W-1:0] thr;

  assign nb_x    = CW'(num_bins);
  assign start_x = CW'(start_bin);
  assign thr     = (threshold < MIN_THRESHOLD) ? MIN_THRESHOLD : threshold;

  always_comb begin
    if (nb_x > CW'(MAX_BINS)) begin
      len = CW'(MAX_BINS);
    end else if (nb_x == '0) begin
      len = CW'(1);
    end else begin
      len = nb_x;
    end
  end

  // bin position; a shortened frame ends on the current bin
  logic [CW-1:0] cnt, kk;
  logic          last_bin;
  logic          accept;

  assign kk       = (cnt >= len) ? len - 1'b1 : cnt;
  assign last_bin = ((kk + 1'b1) >= len);
  assign in_ready = (state == ST_RUN);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= last_bin ? '0 : kk + 1'b1;
    end
  end

  // spectrum memory
  logic [VAL_W-1:0] mem [MAX_BINS];
  logic [VAL_W-1:0] mem_q;
  logic [AW-1:0]    raddr, waddr, clr;
  logic [VAL_W-1:0] wdata;
  logic             we;

  always_ff @(posedge clk) begin
    mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (state == ST_CLEAR) begin
      clr <= clr + 1'b1;
    end
  end

  // averaging stage: data of the item taken last cycle meets the read result
  logic             s1_valid, fwd_hit;
  logic [AW-1:0]    s1_addr;
  logic [VAL_W-1:0] s1_v, fwd_data, old_v, avg;
  logic [VAL_W:0]   sum;

  assign old_v = fwd_hit ? fwd_data : mem_q;
  assign sum   = {1'b0, old_v} + {1'b0, s1_v};
  assign avg   = sum[VAL_W:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr  <= kk[AW-1:0];
    s1_v     <= bin_value;
    // same entry written this cycle: memory read returns the stale value
    fwd_hit  <= s1_valid && (s1_addr == kk[AW-1:0]);
    fwd_data <= avg;
  end

  assign we    = (state == ST_CLEAR) || s1_valid;
  assign waddr = (state == ST_CLEAR) ? clr : s1_addr;
  assign wdata = (state == ST_CLEAR) ? '0 : avg;

  // scan registers
  logic [CW-1:0]    cur, cur_next, cur_inc, pbin, pbin_next;
  logic [CW-1:0]    wj, wj_next, wend, wend_next, wj_d;
  logic [VAL_W-1:0] pval, pval_next;
  logic             res_found, res_found_next;
  logic [REF_W-1:0] res_ref, res_ref_next;
  logic             end_next, sums_clr, div_start, div_done, out_load, wv;
  logic [VSW-1:0]   vsum;
  logic [WSW-1:0]   wsum;
  logic [NW-1:0]    div_num, div_quo;
  logic [VAL_W+CW-1:0] prod;

  assign cur_inc  = cur + 1'b1;
  assign end_next = ((cur_inc + WHC) >= len);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    logic          go_win;
    logic [CW-1:0] pb_w;
    state_next     = state;
    cur_next       = cur;
    pval_next      = pval;
    pbin_next      = pbin;
    wj_next        = wj;
    wend_next      = wend;
    res_found_next = res_found;
    res_ref_next   = res_ref;
    raddr          = '0;
    go_win         = 1'b0;
    pb_w           = pbin;
    sums_clr       = 1'b0;
    div_start      = 1'b0;
    out_load       = 1'b0;
    case (state)
      ST_CLEAR: begin
        if (clr == AW'(MAX_BINS - 1)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        raddr = kk[AW-1:0];
        if (accept && last_bin) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last average lands in memory this cycle
        state_next = ST_FIRST;
      end
      ST_FIRST: begin
        raddr     = start_x[AW-1:0];
        cur_next  = start_x;
        pval_next = '0;
        pbin_next = '0;
        if ((start_x + WHC) >= len) begin
          res_found_next = 1'b0;
          res_ref_next   = '0;
          state_next     = ST_FINISH;
        end else begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        raddr    = cur_inc[AW-1:0];
        cur_next = cur_inc;
        if (mem_q > thr) begin
          pval_next = mem_q;
          pbin_next = cur;
          if (end_next) begin
            go_win = 1'b1;
            pb_w   = cur;
          end else begin
            state_next = ST_CLIMB;
          end
        end else if (end_next) begin
          res_found_next = 1'b0;
          res_ref_next   = '0;
          state_next     = ST_FINISH;
        end
      end
      ST_CLIMB: begin
        raddr = cur_inc[AW-1:0];
        if (mem_q >= pval) begin
          pval_next = mem_q;
          pbin_next = cur;
          cur_next  = cur_inc;
          if (end_next) begin
            go_win = 1'b1;
            pb_w   = cur;
          end
        end else begin
          go_win = 1'b1;
          pb_w   = pbin;
        end
      end
      ST_WINDOW: begin
        raddr   = wj[AW-1:0];
        wj_next = wj + 1'b1;
        if (wj == wend) begin
          state_next = ST_WTAIL;
        end
      end
      ST_WTAIL: begin
        state_next = ST_DIVGO;
      end
      ST_DIVGO: begin
        if (vsum == '0) begin
          res_ref_next = '0;
          state_next   = ST_FINISH;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_ref_next = div_quo[REF_W-1:0];
          state_next   = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
    // window runs from max(0, peak - half) to peak + half; the top end
    // always lies inside the frame
    if (go_win) begin
      wj_next        = (pb_w >= WHC) ? pb_w - WHC : '0;
      wend_next      = pb_w + WHC;
      sums_clr       = 1'b1;
      res_found_next = 1'b1;
      state_next     = ST_WINDOW;
    end
  end

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    pval      <= pval_next;
    pbin      <= pbin_next;
    wj        <= wj_next;
    wend      <= wend_next;
    res_found <= res_found_next;
    res_ref   <= res_ref_next;
  end

  // window sums, one bin per cycle behind the read
  assign prod = mem_q * wj_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      wv <= 1'b0;
    end else begin
      wv <= (state == ST_WINDOW);
    end
  end

  always_ff @(posedge clk) begin
    wj_d <= wj;
    if (sums_clr) begin
      vsum <= '0;
      wsum <= '0;
    end else if (wv) begin
      vsum <= vsum + VSW'(mem_q);
      wsum <= wsum + WSW'(prod);
    end
  end

  // centroid = sum(v*j) * 2*half / sum(v)
  assign div_num = NW'(wsum) * NW'(SCALE);

  aspf_div #(
    .NW (NW),
    .DW (VSW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (vsum),
    .done  (div_done),
    .quo   (div_quo)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found       <= res_found;
      peak_value  <= pval;
      peak_bin    <= pbin[PBIN_W-1:0];
      refined_bin <= res_ref;
    end
  end

endmodule

// File: rtl/core/aspf_check.sv
// Port-level checker for the averaged spectrum peak finder, bound to the top.
// Depends on aspf_pkg and averaged_spectrum_peak_finder_assert.svh.
`timescale 1ns / 1ps
`include "averaged_spectrum_peak_finder_assert.svh"

module aspf_check
  import aspf_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              found,
  input logic [VAL_W-1:0]  peak_value,
  input logic [PBIN_W-1:0] peak_bin,
  input logic [REF_W-1:0]  refined_bin
);

  // a stalled result item keeps its fields
  `ASPF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(found) && $stable(peak_value) && $stable(peak_bin) && $stable(refined_bin), "result item changed while stalled")

  // no peak means an all-zero item
  `ASPF_ASSERT(a_none_zero, out_valid && !found |-> peak_value == '0 && peak_bin == '0 && refined_bin == '0, "empty result carries data")

  // a found peak lies above the floored threshold
  `ASPF_ASSERT(a_peak_level, out_valid && found |-> peak_value > MIN_THRESHOLD, "peak value not above threshold floor")

endmodule

bind averaged_spectrum_peak_finder aspf_check u_aspf_check (.*);
